// ===== src/uss_pkg.sv =====
package uss_pkg;

  // Default table depth
  localparam int SLOT_CNT_DEF = 8;

  // Fixed field widths
  localparam int SEQ_W   = 32;
  localparam int ADDR_W  = 32;
  localparam int ERR_W   = 8;
  localparam int SEL_W   = 4;
  localparam int IDX_W   = 3;
  localparam int CNT_W   = 4;

  // Remainder unit: quotient bits retired per cycle
  localparam int REM_STEP   = 4;
  localparam int REM_CYCLES = SEQ_W / REM_STEP;

  // Configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 4;

  localparam logic [CFG_IDX_W-1:0] REG_SLOTS_IN_USE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_RUN_SLOT     = 1'b1;

  // Input item actions
  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  typedef struct packed {
    logic              action;
    logic [IDX_W-1:0]  slot_index;
    logic [ADDR_W-1:0] entry_map_addr;
    logic              entry_has_fs;
    logic              entry_valid;
    logic              entry_writeable;
    logic [ERR_W-1:0]  entry_err_count;
    logic [ADDR_W-1:0] want_map_addr;
    logic              want_fs;
    logic signed [SEL_W-1:0] exclude_a;
    logic signed [SEL_W-1:0] exclude_b;
    logic [SEQ_W-1:0]  sequence_req;
  } in_item_t;

  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] chosen_slot;
  } out_item_t;

endpackage

// ===== src/uss_rem_unit.sv =====
module uss_rem_unit #(
  parameter int SLOT_CNT = uss_pkg::SLOT_CNT_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  input  logic [uss_pkg::SEQ_W-1:0]             dividend,
  input  logic [$clog2(SLOT_CNT+1)-1:0]         divisor,
  output logic                                  done,
  output logic [$clog2(SLOT_CNT+1)-1:0]         remainder
);
  import uss_pkg::*;

  localparam int NW    = $clog2(SLOT_CNT + 1);
  localparam int CYC_W = (REM_CYCLES > 1) ? $clog2(REM_CYCLES) : 1;
  localparam logic [CYC_W-1:0] CYC_LAST = CYC_W'(REM_CYCLES - 1);

  logic             busy;
  logic [CYC_W-1:0] cyc;
  logic [SEQ_W-1:0] dvd;
  logic [NW-1:0]    rem;
  logic [NW-1:0]    rem_next;
  logic [NW:0]      trial [REM_STEP];
  logic [NW-1:0]    part  [REM_STEP+1];

  // Retire REM_STEP dividend bits: shift in, compare, subtract
  always_comb begin
    part[0] = rem;
    for (int k = 0; k < REM_STEP; k++) begin
      trial[k] = {part[k], dvd[SEQ_W-1-k]};
      if (trial[k] >= (NW+1)'(divisor)) begin
        trial[k] = trial[k] - (NW+1)'(divisor);
      end
      part[k+1] = trial[k][NW-1:0];
    end
    rem_next = part[REM_STEP];
  end

  // Sequence the steps
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cyc  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cyc  <= '0;
      end else if (busy) begin
        cyc <= cyc + CYC_W'(1);
        if (cyc == CYC_LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Hold the working dividend and partial remainder
  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      rem <= '0;
    end else if (busy) begin
      dvd <= dvd << REM_STEP;
      rem <= rem_next;
    end
  end

  assign remainder = rem;

endmodule

// ===== src/update_slot_selector_top.sv =====
// Firmware slot selector. A write item stores one slot entry when it is taken and
// gives no result; writes can be taken back to back. A query item computes
// sequence_req mod slots_in_use (capped at SLOT_CNT) in the remainder unit, four bits
// a cycle, hands the start index to the scan, then walks the n slots in use one
// per cycle keeping the eligible slot with the fewest errors, and loads the result
// register in the finish step once the output register is free; in_ready rises on the
// cycle that the result becomes valid. With no slot in use a query goes from idle
// straight to the finish step. in_ready is low while a query is in progress; a finished
// result may wait in the output register while the next item is taken, and a query that
// finishes while that result still waits holds until it transfers.
module update_slot_selector_top #(
  parameter int SLOT_CNT = uss_pkg::SLOT_CNT_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  uss_pkg::in_item_t                in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output uss_pkg::out_item_t               out_data,
  input  logic                             cfg_we,
  input  logic [uss_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [uss_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import uss_pkg::*;

  localparam int NW = $clog2(SLOT_CNT + 1);
  localparam int IW = (SLOT_CNT > 1) ? $clog2(SLOT_CNT) : 1;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_MOD    = 4'b0010,
    ST_SCAN   = 4'b0100,
    ST_FINISH = 4'b1000
  } state_t;

  function automatic logic sel_hit(logic [SEL_W-1:0] sel, logic [IW-1:0] idx);
    sel_hit = !sel[SEL_W-1] && (SEL_W'(idx) == {1'b0, sel[SEL_W-2:0]});
  endfunction

  state_t            state;
  logic [CNT_W-1:0]  slots_in_use;
  logic [SEL_W-1:0]  run_slot;

  logic [ADDR_W-1:0] slot_map_address  [SLOT_CNT];
  logic              slot_fs_present   [SLOT_CNT];
  logic              slot_is_valid     [SLOT_CNT];
  logic              slot_is_writeable [SLOT_CNT];
  logic [ERR_W-1:0]  slot_errors       [SLOT_CNT];

  in_item_t          query;
  logic [NW-1:0]     n_eff;
  logic [NW-1:0]     n_q;
  logic [IW-1:0]     idx;
  logic [SEQ_W-1:0]  cur;
  logic [NW-1:0]     visits;
  logic              have;
  logic [IW-1:0]     best;
  logic [ERR_W-1:0]  best_err;

  logic              in_xfer;
  logic              wr_hit;
  logic              rem_start;
  logic              rem_done;
  logic [NW-1:0]     rem_val;
  logic              eligible;
  logic              better;
  logic              last_visit;
  logic              out_free;

  assign in_ready  = (state == ST_IDLE);
  assign in_xfer   = in_valid && in_ready;
  assign wr_hit    = (32'(in_data.slot_index) < 32'(SLOT_CNT));
  assign n_eff     = (32'(slots_in_use) > 32'(SLOT_CNT)) ? NW'(SLOT_CNT)
                                                         : NW'(slots_in_use);
  assign rem_start = in_xfer && (in_data.action == ACT_QUERY) && (n_eff != '0);
  assign out_free  = !out_valid || out_ready;

  uss_rem_unit #(
    .SLOT_CNT(SLOT_CNT)
  ) u_rem (
    .clk       (clk),
    .rst       (rst),
    .start     (rem_start),
    .dividend  (in_data.sequence_req),
    .divisor   (n_eff),
    .done      (rem_done),
    .remainder (rem_val)
  );

  // Judge the slot under visit
  always_comb begin
    eligible = !sel_hit(run_slot, idx)
            && ((query.want_map_addr == '0) || (slot_map_address[idx] == query.want_map_addr))
            && (!query.want_fs || slot_fs_present[idx])
            && !sel_hit(query.exclude_a, idx)
            && !sel_hit(query.exclude_b, idx)
            && slot_is_valid[idx] && slot_is_writeable[idx];
    better     = eligible && (!have || (slot_errors[idx] < best_err));
    last_visit = ((visits + NW'(1)) == n_q);
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      slots_in_use <= CNT_W'(8);
      run_slot     <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SLOTS_IN_USE: slots_in_use <= cfg_data;
        REG_RUN_SLOT:     run_slot     <= cfg_data;
        default: ;
      endcase
    end
  end

  // Slot table: only the valid and writeable bits need clearing
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < SLOT_CNT; k++) begin
        slot_is_valid[k]     <= 1'b0;
        slot_is_writeable[k] <= 1'b0;
      end
    end else if (in_xfer && (in_data.action == ACT_WRITE) && wr_hit) begin
      slot_is_valid[IW'(in_data.slot_index)]     <= in_data.entry_valid;
      slot_is_writeable[IW'(in_data.slot_index)] <= in_data.entry_writeable;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer && (in_data.action == ACT_WRITE) && wr_hit) begin
      slot_map_address[IW'(in_data.slot_index)] <= in_data.entry_map_addr;
      slot_fs_present[IW'(in_data.slot_index)]  <= in_data.entry_has_fs;
      slot_errors[IW'(in_data.slot_index)]      <= in_data.entry_err_count;
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      have  <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_xfer && (in_data.action == ACT_QUERY)) begin
            have  <= 1'b0;
            state <= (n_eff == '0) ? ST_FINISH : ST_MOD;
          end
        end
        ST_MOD: begin
          if (rem_done) begin
            state <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (better) begin
            have <= 1'b1;
          end
          if (last_visit) begin
            state <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Raise the result on the finish step, drop it on its transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_FINISH && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Datapath of the scan
  always_ff @(posedge clk) begin
    if (in_xfer && (in_data.action == ACT_QUERY)) begin
      query <= in_data;
      n_q   <= n_eff;
    end
    if (state == ST_MOD && rem_done) begin
      idx    <= rem_val[IW-1:0];
      cur    <= query.sequence_req;
      visits <= '0;
    end
    if (state == ST_SCAN) begin
      if (better) begin
        best     <= idx;
        best_err <= slot_errors[idx];
      end
      // Follow the 32-bit wrap of sequence + visit, then the modulus
      if ((cur == '1) || ((NW'(idx) + NW'(1)) == n_q)) begin
        idx <= '0;
      end else begin
        idx <= idx + IW'(1);
      end
      cur    <= cur + SEQ_W'(1);
      visits <= visits + NW'(1);
    end
    if (state == ST_FINISH && out_free) begin
      out_data.found       <= have;
      out_data.chosen_slot <= have ? IDX_W'(best) : '0;
    end
  end

  a_no_slot_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.found |-> out_data.chosen_slot == '0)
    else $error("chosen_slot nonzero without a found slot");

  a_rem_in_mod: assert property (@(posedge clk) disable iff (rst)
    rem_done |-> state == ST_MOD)
    else $error("remainder finished outside of its step");

  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    state == ST_SCAN |-> visits < n_q)
    else $error("scan ran past the slots in use");

  a_finish_loads: assert property (@(posedge clk) disable iff (rst)
    state == ST_FINISH && out_free |=> state == ST_IDLE && out_valid)
    else $error("result not loaded at end of query");

endmodule
